// ===== design/spbf_pkg.sv =====
`default_nettype none
package spbf_pkg;

  localparam int unsigned NumSeg = 6;
  localparam logic [7:0] Flip = 8'h20;

  localparam logic [2:0] CfgStart   = 3'd0;
  localparam logic [2:0] CfgEnd     = 3'd1;
  localparam logic [2:0] CfgChannel = 3'd2;
  localparam logic [2:0] CfgPktEsc  = 3'd3;
  localparam logic [2:0] CfgIdle    = 3'd4;
  localparam logic [2:0] CfgLineEsc = 3'd5;
  localparam logic [2:0] CfgChanNum = 3'd6;

  localparam logic [2:0] SegStart   = 3'd0;
  localparam logic [2:0] SegChannel = 3'd1;
  localparam logic [2:0] SegChanNum = 3'd2;
  localparam logic [2:0] SegEnd     = 3'd3;
  localparam logic [2:0] SegData    = 3'd4;
  localparam logic [2:0] SegFlipped = 3'd5;

  typedef enum logic [5:0] {
    PhHunt   = 6'b000001,
    PhIn     = 6'b000010,
    PhEsc    = 6'b000100,
    PhChan   = 6'b001000,
    PhEop    = 6'b010000,
    PhEopEsc = 6'b100000
  } rx_phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       packet_end;
  } in_t;

  typedef struct packed {
    logic       direction;
    logic [7:0] out_byte;
    logic       payload_last;
    logic       run_last;
  } out_t;

endpackage
`default_nettype wire

// ===== design/spi_packet_byte_framer_top.sv =====
// Channel   Signals                                   Transfer
// in        in_valid_i  in_ready_o  in_data_i         valid && ready at clk_i rise
// out       out_valid_o out_ready_i out_data_o        valid && ready at clk_i rise
// cfg       cfg_we_i cfg_idx_i cfg_data_i             cfg_we_i at clk_i rise
//
// An accepted item is expanded at once into up to six line-layer segments; the
// output stage drains one byte per cycle while out_ready_i is high, one or two per segment.
// Transmit items produce 1 to 12 output bytes, receive items 0 or 1.
// A new item is taken in the cycle the previous item's last byte transfers.
// rst_ni clears framing state and restores register defaults.
// Output stalls hold the segment buffer and block input.
`default_nettype none
module spi_packet_byte_framer_top
  import spbf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0] start_q, end_q, chan_q, pesc_q, idle_q, lesc_q, chnum_q;

  logic      tx_in_pkt_q, tx_in_pkt_d;
  logic      rx_lesc_q, rx_lesc_d;
  rx_phase_e rx_phase_q, rx_phase_d;

  logic [7:0]        seg_byte_q [NumSeg];
  logic [7:0]        seg_byte_d [NumSeg];
  logic [NumSeg-1:0] seg_esc_q, seg_esc_d;
  logic [NumSeg-1:0] mask_q, mask_d, new_mask;
  logic              sub_q, sub_d;
  logic              dir_q, dir_d;
  logic              rx_last_q, rx_last_d;

  logic       in_fire, out_fire, last_take;
  logic [2:0] cur;
  logic [NumSeg-1:0] mask_after;
  logic       special;
  logic [7:0] pb;
  logic       rx_go, rx_res, rx_res_last;
  logic [7:0] rx_res_byte;

  always_comb begin
    cur = '0;
    for (int i = NumSeg - 1; i >= 0; i--) begin
      if (mask_q[i]) cur = 3'(i);
    end
  end

  always_comb begin
    mask_after      = mask_q;
    mask_after[cur] = 1'b0;
  end

  assign out_valid_o = |mask_q;
  assign last_take   = (sub_q || !seg_esc_q[cur]) && (mask_after == '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_ready_i && last_take);
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    out_data_o.direction    = dir_q;
    out_data_o.out_byte     = (seg_esc_q[cur] && !sub_q) ? lesc_q : (seg_byte_q[cur] ^ {8{sub_q}} & Flip);
    out_data_o.payload_last = rx_last_q;
    out_data_o.run_last     = last_take;
  end

  // receive path
  assign pb    = rx_lesc_q ? (in_data_i.data_byte ^ Flip) : in_data_i.data_byte;
  assign rx_go = rx_lesc_q || ((in_data_i.data_byte != idle_q) &&
                               (in_data_i.data_byte != lesc_q));

  always_comb begin
    rx_phase_d  = rx_phase_q;
    rx_res      = 1'b0;
    rx_res_byte = pb;
    rx_res_last = 1'b0;
    rx_lesc_d   = 1'b0;
    if (!rx_lesc_q && (in_data_i.data_byte != idle_q) && (in_data_i.data_byte == lesc_q)) begin
      rx_lesc_d = 1'b1;
    end
    if (rx_go) begin
      unique case (rx_phase_q)
        PhIn: begin
          if (pb == start_q)     rx_phase_d = PhIn;
          else if (pb == end_q)  rx_phase_d = PhEop;
          else if (pb == chan_q) rx_phase_d = PhChan;
          else if (pb == pesc_q) rx_phase_d = PhEsc;
          else                   rx_res     = 1'b1;
        end
        PhEsc: begin
          rx_res      = 1'b1;
          rx_res_byte = pb ^ Flip;
          rx_phase_d  = PhIn;
        end
        PhChan: rx_phase_d = PhIn;
        PhEop: begin
          if (pb == pesc_q) rx_phase_d = PhEopEsc;
          else if (pb == start_q) rx_phase_d = PhIn;
          else begin
            rx_res      = 1'b1;
            rx_res_last = 1'b1;
            rx_phase_d  = PhHunt;
          end
        end
        PhEopEsc: begin
          rx_res      = 1'b1;
          rx_res_byte = pb ^ Flip;
          rx_res_last = 1'b1;
          rx_phase_d  = PhHunt;
        end
        default: rx_phase_d = (pb == start_q) ? PhIn : PhHunt;
      endcase
    end
  end

  // transmit segment build
  assign special = (in_data_i.data_byte == start_q) || (in_data_i.data_byte == end_q) ||
                   (in_data_i.data_byte == chan_q) || (in_data_i.data_byte == pesc_q);

  always_comb begin
    seg_byte_d = seg_byte_q;
    seg_esc_d  = seg_esc_q;
    new_mask   = '0;
    dir_d      = dir_q;
    rx_last_d  = rx_last_q;
    if (in_data_i.kind == 1'b0) begin
      seg_byte_d[SegStart]   = start_q;
      seg_byte_d[SegChannel] = chan_q;
      seg_byte_d[SegChanNum] = chnum_q;
      seg_byte_d[SegEnd]     = end_q;
      seg_byte_d[SegData]    = special ? pesc_q : in_data_i.data_byte;
      seg_byte_d[SegFlipped] = in_data_i.data_byte ^ Flip;
      new_mask[SegStart]     = !tx_in_pkt_q;
      new_mask[SegChannel]   = !tx_in_pkt_q;
      new_mask[SegChanNum]   = !tx_in_pkt_q;
      new_mask[SegEnd]       = in_data_i.packet_end;
      new_mask[SegData]      = 1'b1;
      new_mask[SegFlipped]   = special;
      for (int i = 0; i < NumSeg; i++) begin
        seg_esc_d[i] = (seg_byte_d[i] == idle_q) || (seg_byte_d[i] == lesc_q);
      end
      dir_d     = 1'b0;
      rx_last_d = 1'b0;
    end else begin
      seg_byte_d[SegStart] = rx_res_byte;
      seg_esc_d            = '0;
      new_mask[SegStart]   = rx_res;
      dir_d                = 1'b1;
      rx_last_d            = rx_res_last;
    end
  end

  always_comb begin
    mask_d      = mask_q;
    sub_d       = sub_q;
    tx_in_pkt_d = tx_in_pkt_q;
    if (out_fire) begin
      if (seg_esc_q[cur] && !sub_q) begin
        sub_d = 1'b1;
      end else begin
        sub_d  = 1'b0;
        mask_d = mask_after;
      end
    end
    if (in_fire) begin
      mask_d = new_mask;
      sub_d  = 1'b0;
      if (in_data_i.kind == 1'b0) tx_in_pkt_d = !in_data_i.packet_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      sub_q       <= 1'b0;
      tx_in_pkt_q <= 1'b0;
      rx_lesc_q   <= 1'b0;
      rx_phase_q  <= PhHunt;
    end else begin
      mask_q      <= mask_d;
      sub_q       <= sub_d;
      tx_in_pkt_q <= tx_in_pkt_d;
      if (in_fire && in_data_i.kind) begin
        rx_lesc_q  <= rx_lesc_d;
        rx_phase_q <= rx_phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seg_byte_q <= seg_byte_d;
      seg_esc_q  <= seg_esc_d;
      dir_q      <= dir_d;
      rx_last_q  <= rx_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 8'd122;
      end_q   <= 8'd123;
      chan_q  <= 8'd124;
      pesc_q  <= 8'd125;
      idle_q  <= 8'd74;
      lesc_q  <= 8'd77;
      chnum_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStart:   start_q <= cfg_data_i;
        CfgEnd:     end_q   <= cfg_data_i;
        CfgChannel: chan_q  <= cfg_data_i;
        CfgPktEsc:  pesc_q  <= cfg_data_i;
        CfgIdle:    idle_q  <= cfg_data_i;
        CfgLineEsc: lesc_q  <= cfg_data_i;
        CfgChanNum: chnum_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("input blocked with empty buffer");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.run_last && !in_fire) |=> !out_valid_o)
    else $error("bytes left after run_last");

  a_tx_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_data_i.kind) |=> (out_valid_o && !out_data_o.direction))
    else $error("transmit item produced nothing");

  a_rx_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.direction) |-> out_data_o.run_last)
    else $error("receive item produced more than one byte");
`endif

endmodule
`default_nettype wire
